[sv/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the point slope traversability block
// Payload structs, register indexes, fixed field widths and default sizes.
// ----------------------------------------------------------------------------
package pst_pkg;

   // Fixed field widths of the transactions
   localparam int COORD_FIELD_WIDTH = 24;
   localparam int COORD_RAW_WIDTH   = 32;   // widest coordinate the block accepts
   localparam int RSP_COUNT_WIDTH   = 11;
   localparam int SLOPE_WIDTH       = 32;   // unsigned Q16.16
   localparam int RATIO_WIDTH       = 17;   // unsigned Q0.16 plus one bit above 1.0
   localparam int FRAC_BITS         = 16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOPE_TAN_SQ = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATIO_LIMIT  = 1'd1;
   localparam logic [SLOPE_WIDTH-1:0] SLOPE_TAN_SQ_RESET = 32'd46143;
   localparam logic [RATIO_WIDTH-1:0] RATIO_LIMIT_RESET  = 17'd9830;

   // Default sizes
   localparam int DEF_MAX_NEIGHBORS = 1024;
   localparam int DEF_COORD_WIDTH   = 24;
   localparam int MID_DEPTH         = 4;
   localparam int OUT_DEPTH         = 8;

   // Width of the count of verdicts in flight: at most six (five stages plus verdict)
   localparam int INFLIGHT_WIDTH = 3;

   typedef struct packed {
      logic signed [COORD_FIELD_WIDTH-1:0] center_x;
      logic signed [COORD_FIELD_WIDTH-1:0] center_y;
      logic signed [COORD_FIELD_WIDTH-1:0] center_z;
      logic signed [COORD_FIELD_WIDTH-1:0] nbr_x;
      logic signed [COORD_FIELD_WIDTH-1:0] nbr_y;
      logic signed [COORD_FIELD_WIDTH-1:0] nbr_z;
      logic                                is_self;
      logic                                last_nbr;
   } req_type;

   typedef struct packed {
      logic                       traversable;
      logic [RSP_COUNT_WIDTH-1:0] steep_count;
      logic [RSP_COUNT_WIDTH-1:0] neighbour_count;
   } rsp_type;

   typedef struct packed {
      logic [SLOPE_WIDTH-1:0] slope_tan_sq;
      logic [RATIO_WIDTH-1:0] ratio_limit;
   } csr_type;

endpackage

[sv/point_slope_traversability_top.sv]
// ----------------------------------------------------------------------------
// point_slope_traversability_top: lidar point traversability classifier
// Counts steep radius neighbours of a centre point and issues a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req_data and raise req_push; a transaction
//   is taken on a clock edge with req_push high and req_full low. Each
//   transaction carries the centre point and one neighbour; last_nbr closes
//   the point. Only a closing transaction yields a response.
//   Response side is a queue: while rsp_empty is low the oldest verdict sits
//   on rsp_data; rsp_pop high at a clock edge takes it.
//   Registers are written through csr_we/csr_index/csr_wdata at any edge with
//   csr_we high; write them only while the block is idle.
// Timing:
//   One transaction per cycle sustained unless the response queue backs up. A
//   verdict reaches rsp_data after the closing transaction passes the intake
//   queue, five pipeline stages of the slope test (differences, squares,
//   horizontal sum, split 49x32 threshold product, wide compare) and the
//   counter update and verdict register. The verdict multiply goes into the queue.
// Reset:
//   Synchronous, active high. Clears both queues, the pipeline, the counters
//   and restores the register defaults.
// Stall:
//   The back end issues only while the response queue has room for every
//   verdict in flight, so a stalled receiver backs up into the intake queue
//   and then raises req_full; nothing is dropped.
// ----------------------------------------------------------------------------
module point_slope_traversability_top import pst_pkg::*; #(
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request queue
   input  logic                        req_push,
   input  req_type                     req_data,
   output logic                        req_full,
   // Response queue
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output rsp_type                     rsp_data,
   // Register writes
   input  logic                        csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int MID_W     = 3 * COORD_WIDTH + 2;
   localparam int RSP_W     = $bits(rsp_type);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int CREDIT_W  = OUT_CNT_W + 1;

   logic [SLOPE_WIDTH-1:0] slope_tan_sq_ff, slope_tan_sq_in;
   logic [RATIO_WIDTH-1:0] ratio_limit_ff, ratio_limit_in;
   csr_type                csr;

   logic                          mid_push, mid_full, mid_empty;
   logic [MID_W-1:0]              mid_item, mid_head;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

   logic                          issue;
   logic                          back_valid;
   rsp_type                       back_data;
   logic [INFLIGHT_WIDTH-1:0]     inflight;
   logic                          out_full;
   logic [OUT_CNT_W-1:0]          out_count;
   logic [RSP_W-1:0]              out_head;
   logic [CREDIT_W-1:0]           credit_used;

   // Register file: hold values between writes
   always_comb begin
      slope_tan_sq_in = slope_tan_sq_ff;
      ratio_limit_in  = ratio_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOPE_TAN_SQ: slope_tan_sq_in = csr_wdata[SLOPE_WIDTH-1:0];
            CSR_RATIO_LIMIT:  ratio_limit_in  = csr_wdata[RATIO_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_tan_sq_ff <= SLOPE_TAN_SQ_RESET;
         ratio_limit_ff  <= RATIO_LIMIT_RESET;
      end else begin
         slope_tan_sq_ff <= slope_tan_sq_in;
         ratio_limit_ff  <= ratio_limit_in;
      end
   end

   assign csr.slope_tan_sq = slope_tan_sq_ff;
   assign csr.ratio_limit  = ratio_limit_ff;

   // Front: classify and take differences
   pst_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .req_push (req_push),
      .req_data (req_data),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_item (mid_item)
   );

   // Decouple intake from the slope pipeline
   pst_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (mid_item),
      .pop   (issue),
      .dout  (mid_head),
      .full  (mid_full),
      .empty (mid_empty),
      .count (mid_count)
   );

   assign req_full = mid_full;

   // Issue only when every verdict in flight already owns a response slot
   assign credit_used = CREDIT_W'(out_count) + CREDIT_W'(inflight);
   assign issue       = !mid_empty && (credit_used < CREDIT_W'(OUT_DEPTH));

   pst_back #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .COORD_WIDTH   (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .in_item   (mid_head),
      .csr       (csr),
      .rsp_valid (back_valid),
      .rsp_data  (back_data),
      .inflight  (inflight)
   );

   // Response queue: let the back end run while the receiver stalls
   pst_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (back_valid),
      .din   (back_data),
      .pop   (rsp_pop),
      .dout  (out_head),
      .full  (out_full),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_data = rsp_type'(out_head);

   // Never drop a verdict: the credit check must leave room in the queue
   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_valid |-> !out_full)
      else $error("response queue overflow");

   // Never issue from an empty intake queue
   a_issue_has_item: assert property (@(posedge clock) disable iff (reset)
      issue |-> (mid_count != '0))
      else $error("issue from empty intake queue");

   // Verdicts queued plus in flight stay within the response queue
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= CREDIT_W'(OUT_DEPTH))
      else $error("response credit exceeded");

endmodule

[sv/pst_fifo.sv]
// ----------------------------------------------------------------------------
// pst_fifo: small register queue
// First-in first-out buffer with head data shown while not empty.
// ----------------------------------------------------------------------------
module pst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4   // power of two
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               din,
   input  logic                           pop,
   output logic [WIDTH-1:0]               dout,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[sv/pst_front.sv]
// ----------------------------------------------------------------------------
// pst_front: intake and classification
// Extracts coordinates, forms absolute axis differences and tags each
// transaction as self or counted neighbour and as end of point.
// ----------------------------------------------------------------------------
module pst_front import pst_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                         req_push,
   input  req_type                      req_data,
   input  logic                         mid_full,
   output logic                         mid_push,
   output logic [3*COORD_WIDTH+1:0]     mid_item
);

   localparam int CW = COORD_WIDTH;

   // Take the low CW bits of the zero-extended field as two's complement
   function automatic logic signed [CW-1:0] coord(input logic [COORD_FIELD_WIDTH-1:0] f);
      logic [COORD_RAW_WIDTH-1:0] raw;
      raw = {{(COORD_RAW_WIDTH-COORD_FIELD_WIDTH){1'b0}}, f};
      return signed'(raw[CW-1:0]);
   endfunction

   function automatic logic [CW-1:0] abs_diff(input logic [COORD_FIELD_WIDTH-1:0] a,
                                              input logic [COORD_FIELD_WIDTH-1:0] b);
      logic signed [CW:0] d;
      logic signed [CW:0] m;
      d = (CW+1)'(coord(a)) - (CW+1)'(coord(b));
      m = d[CW] ? -d : d;
      return m[CW-1:0];
   endfunction

   logic [CW-1:0] adx, ady, adz;

   assign adx = abs_diff(req_data.center_x, req_data.nbr_x);
   assign ady = abs_diff(req_data.center_y, req_data.nbr_y);
   assign adz = abs_diff(req_data.center_z, req_data.nbr_z);

   assign mid_push = req_push && !mid_full;
   assign mid_item = {req_data.is_self, req_data.last_nbr, adx, ady, adz};

endmodule

[sv/pst_back.sv]
// ----------------------------------------------------------------------------
// pst_back: slope test, neighbour counters and verdict
// Five-stage pipelined exact slope test feeding the saturating counters;
// the verdict is formed from the registered final counts.
// ----------------------------------------------------------------------------
module pst_back import pst_pkg::*; #(
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         issue,
   input  logic [3*COORD_WIDTH+1:0]     in_item,
   input  csr_type                      csr,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data,
   output logic [INFLIGHT_WIDTH-1:0]    inflight
);

   localparam int CW     = COORD_WIDTH;
   localparam int SQ_W   = 2 * CW;
   localparam int H_W    = SQ_W + 1;
   localparam int HLO_W  = (H_W + 1) / 2;
   localparam int HHI_W  = H_W - HLO_W;
   localparam int PLO_W  = HLO_W + SLOPE_WIDTH;
   localparam int PHI_W  = HHI_W + SLOPE_WIDTH;
   localparam int LHS_W  = SQ_W + FRAC_BITS;
   localparam int RHS_W  = H_W + SLOPE_WIDTH;
   localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
   localparam int VP_W   = CNT_W + RATIO_WIDTH;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c >= CNT_W'(MAX_NEIGHBORS)) ? CNT_W'(MAX_NEIGHBORS) : c + CNT_W'(1);
   endfunction

   // Stage 1: differences
   logic            s1_valid_ff, s1_count_ff, s1_last_ff;
   logic [CW-1:0]   s1_dx_ff, s1_dy_ff, s1_dz_ff;
   // Stage 2: squares
   logic            s2_valid_ff, s2_count_ff, s2_last_ff;
   logic [SQ_W-1:0] s2_dx2_ff, s2_dy2_ff, s2_dz2_ff;
   // Stage 3: horizontal distance squared
   logic            s3_valid_ff, s3_count_ff, s3_last_ff;
   logic [H_W-1:0]  s3_h2_ff;
   logic [SQ_W-1:0] s3_dz2_ff;
   // Stage 4: partial products of the threshold
   logic             s4_valid_ff, s4_count_ff, s4_last_ff, s4_nz_ff;
   logic [PLO_W-1:0] s4_plo_ff;
   logic [PHI_W-1:0] s4_phi_ff;
   logic [LHS_W-1:0] s4_lhs_ff;
   // Stage 5: steep flag
   logic            s5_valid_ff, s5_count_ff, s5_last_ff, s5_steep_ff;
   logic [RHS_W-1:0] rhs;
   // Counters and verdict capture
   logic [CNT_W-1:0] steep_counter_ff, steep_counter_in;
   logic [CNT_W-1:0] total_counter_ff, total_counter_in;
   logic [CNT_W-1:0] steep_next, total_next;
   logic             v_valid_ff;
   logic [CNT_W-1:0] v_steep_ff, v_total_ff;
   logic [VP_W-1:0]  v_lhs, v_rhs;
   logic [31:0]      steep_wide, total_wide;

   // Control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         v_valid_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_last_ff  <= 1'b0;
         s3_last_ff  <= 1'b0;
         s4_last_ff  <= 1'b0;
         s5_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         v_valid_ff  <= s5_valid_ff && s5_last_ff;
         s1_last_ff  <= issue && in_item[3*CW];
         s2_last_ff  <= s1_last_ff;
         s3_last_ff  <= s2_last_ff;
         s4_last_ff  <= s3_last_ff;
         s5_last_ff  <= s4_last_ff;
      end
   end

   assign rhs = RHS_W'(s4_plo_ff) + (RHS_W'(s4_phi_ff) << HLO_W);

   // Datapath
   always_ff @(posedge clock) begin
      s1_count_ff <= !in_item[3*CW+1];
      s1_dx_ff    <= in_item[3*CW-1:2*CW];
      s1_dy_ff    <= in_item[2*CW-1:CW];
      s1_dz_ff    <= in_item[CW-1:0];

      s2_count_ff <= s1_count_ff;
      s2_dx2_ff   <= SQ_W'(s1_dx_ff) * SQ_W'(s1_dx_ff);
      s2_dy2_ff   <= SQ_W'(s1_dy_ff) * SQ_W'(s1_dy_ff);
      s2_dz2_ff   <= SQ_W'(s1_dz_ff) * SQ_W'(s1_dz_ff);

      s3_count_ff <= s2_count_ff;
      s3_h2_ff    <= H_W'(s2_dx2_ff) + H_W'(s2_dy2_ff);
      s3_dz2_ff   <= s2_dz2_ff;

      s4_count_ff <= s3_count_ff;
      s4_nz_ff    <= (s3_h2_ff != '0);
      s4_plo_ff   <= PLO_W'(s3_h2_ff[HLO_W-1:0]) * PLO_W'(csr.slope_tan_sq);
      s4_phi_ff   <= PHI_W'(s3_h2_ff[H_W-1:HLO_W]) * PHI_W'(csr.slope_tan_sq);
      s4_lhs_ff   <= {s3_dz2_ff, {FRAC_BITS{1'b0}}};

      // Zero horizontal distance is never steep
      s5_count_ff <= s4_count_ff;
      s5_steep_ff <= s4_count_ff && s4_nz_ff && (RHS_W'(s4_lhs_ff) > rhs);
   end

   always_comb begin
      total_next       = s5_count_ff ? sat_inc(total_counter_ff) : total_counter_ff;
      steep_next       = s5_steep_ff ? sat_inc(steep_counter_ff) : steep_counter_ff;
      total_counter_in = total_counter_ff;
      steep_counter_in = steep_counter_ff;
      if (s5_valid_ff) begin
         total_counter_in = s5_last_ff ? '0 : total_next;
         steep_counter_in = s5_last_ff ? '0 : steep_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_counter_ff <= '0;
         steep_counter_ff <= '0;
      end else begin
         total_counter_ff <= total_counter_in;
         steep_counter_ff <= steep_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff && s5_last_ff) begin
         v_steep_ff <= steep_next;
         v_total_ff <= total_next;
      end
   end

   // Verdict: steep * 2^16 <= ratio * total, with at least one neighbour
   assign v_lhs      = VP_W'({v_steep_ff, {FRAC_BITS{1'b0}}});
   assign v_rhs      = VP_W'(csr.ratio_limit) * VP_W'(v_total_ff);
   assign steep_wide = 32'(v_steep_ff);
   assign total_wide = 32'(v_total_ff);

   assign rsp_valid                = v_valid_ff;
   assign rsp_data.traversable     = (v_total_ff != '0) && (v_lhs <= v_rhs);
   assign rsp_data.steep_count     = steep_wide[RSP_COUNT_WIDTH-1:0];
   assign rsp_data.neighbour_count = total_wide[RSP_COUNT_WIDTH-1:0];

   assign inflight = INFLIGHT_WIDTH'(s1_last_ff) + INFLIGHT_WIDTH'(s2_last_ff)
                   + INFLIGHT_WIDTH'(s3_last_ff) + INFLIGHT_WIDTH'(s4_last_ff)
                   + INFLIGHT_WIDTH'(s5_last_ff) + INFLIGHT_WIDTH'(v_valid_ff);

endmodule
